[rtl/wcb_pkg.sv]
// ----------------------------------------------------------------------------
// wcb_pkg: shared definitions for the windowed convolution engine
// Sizes of the frame and tap stores, operation, status and register codes,
// and the sequencer state type.
// ----------------------------------------------------------------------------
package wcb_pkg;

  // Store geometry.
  localparam int MAX_HALF  = 7;
  localparam int MAX_ROWS  = 256;
  localparam int MAX_COLS  = 256;
  localparam int TAP_SIDE  = 2 * MAX_HALF + 1;
  localparam int TAP_DEPTH = TAP_SIDE * TAP_SIDE;
  localparam int TAP_AW    = $clog2(TAP_DEPTH);
  localparam int PIX_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int PIX_AW    = $clog2(PIX_DEPTH);

  // Operation codes of an input beat.
  localparam logic [1:0] OP_WEIGHT  = 2'd0;
  localparam logic [1:0] OP_PIXEL   = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FRAME  = 2'd1;
  localparam logic [1:0] ST_BORDER = 2'd2;

  // Border handling modes.
  localparam logic [1:0] BM_REFLECT = 2'd0;
  localparam logic [1:0] BM_CLAMP   = 2'd1;
  localparam logic [1:0] BM_VALID   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_HALF_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_HALF_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_FRAME_ROWS   = 3'd2;
  localparam logic [2:0] CFG_FRAME_COLS   = 3'd3;
  localparam logic [2:0] CFG_BORDER_MODE  = 3'd4;
  localparam logic [2:0] CFG_OUTPUT_SCALE = 3'd5;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_MUL_LO,
    S_MUL_HI,
    S_ROUND,
    S_EMIT
  } seq_state_t;

endpackage

[rtl/window_convolve_with_borders.sv]
// ----------------------------------------------------------------------------
// window_convolve_with_borders: 2D windowed convolution engine
// Stores tap weights and frame pixels in synchronous memories and computes a
// scaled, rounded and saturated window sum at a requested position, with
// reflect, clamp or valid-interior border handling.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------
//  in_     | input     | in_valid/in_stall  | operation, row, col, tap, pixel
//  out_    | output    | out_valid/out_stall| filtered_value, status
//  cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
//  Weight and pixel writes may follow back to back. A compute beat walks
//  the window with the single multiply-accumulate, reading one tap and one
//  pixel from memory per cycle; a position rejected by the border checks
//  skips the walk and goes straight to the emit state.
//  Reset (rst_n low, synchronous) clears control state and loads register
//  defaults; the stores are not cleared and need no clearing pass.
//  A stalled result sits in the output register; the next input beat is
//  taken meanwhile, and a new result waits in the last state until it frees.
// ----------------------------------------------------------------------------
module window_convolve_with_borders (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [7:0]         in_row,
  input  logic [7:0]         in_col,
  input  logic [7:0]         in_tap_index,
  input  logic signed [19:0] in_tap_weight,
  input  logic signed [15:0] in_pixel_value,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_filtered_value,
  output logic [1:0]         out_status,
  // Configuration port.
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  // Configuration registers.
  logic [2:0]  half_width_r;
  logic [2:0]  half_height_r;
  logic [8:0]  frame_rows_r;
  logic [8:0]  frame_cols_r;
  logic [1:0]  border_mode_r;
  logic [23:0] output_scale_r;

  // Sequencer and datapath registers.
  wcb_pkg::seq_state_t state_r, state_nxt;
  logic [7:0]          row_r, col_r;
  logic [3:0]          tx_r, ty_r;
  logic [wcb_pkg::TAP_AW-1:0] tap_r;
  logic [1:0]          status_r;
  logic signed [19:0]  rd_w_r;
  logic signed [15:0]  rd_p_r;
  logic                rd_vld_r;
  logic signed [35:0]  prod_r;
  logic                prod_vld_r;
  logic signed [43:0]  acc_r;
  logic [43:0]         mag_r;
  logic                neg_r;
  logic [45:0]         p0_r, p1_r;
  logic [51:0]         res_r;
  logic                out_valid_r, out_valid_nxt;
  logic signed [47:0]  out_value_r;
  logic [1:0]          out_status_r;

  // Memories.
  logic signed [15:0] frame_mem [wcb_pkg::PIX_DEPTH];
  logic signed [19:0] weight_mem [wcb_pkg::TAP_DEPTH];

  // Combinational signals.
  logic [2:0]  hw_eff, hh_eff;
  logic [8:0]  nr_eff, nc_eff;
  logic        reflect;
  logic        in_acc;
  logic        emit_go;
  logic        tx_last, ty_last;
  logic        outside_frame, outside_valid;
  logic signed [10:0] iy_raw, ix_raw;
  logic [7:0]  iy, ix;
  logic [wcb_pkg::PIX_AW-1:0] pix_wr_addr, pix_rd_addr;
  logic        pix_we, tap_we;
  logic [67:0] round_sum;
  logic signed [47:0] sat_value;

  // Edge handling of one coordinate: optional mirror, then clamp to 0..n-1.
  function automatic logic [7:0] edge_idx(input logic signed [10:0] i,
                                          input logic [8:0] n,
                                          input logic refl);
    logic signed [11:0] v;
    logic signed [11:0] ns;
    ns = $signed({3'b000, n});
    v  = {i[10], i};
    if (refl) begin
      if (v < 12'sd0) begin
        v = -v - 12'sd1;
      end else if (v >= ns) begin
        v = ns + ns - v - 12'sd1;
      end
    end
    if (v < 12'sd0) begin
      v = 12'sd0;
    end else if (v >= ns) begin
      v = ns - 12'sd1;
    end
    return v[7:0];
  endfunction

  // Saturate configuration values into their legal ranges.
  always_comb begin
    hw_eff = (half_width_r == 3'd0) ? 3'd1 : half_width_r;
    hh_eff = (half_height_r == 3'd0) ? 3'd1 : half_height_r;
    if (frame_rows_r == 9'd0) begin
      nr_eff = 9'd1;
    end else if (frame_rows_r > 9'(wcb_pkg::MAX_ROWS)) begin
      nr_eff = 9'(wcb_pkg::MAX_ROWS);
    end else begin
      nr_eff = frame_rows_r;
    end
    if (frame_cols_r == 9'd0) begin
      nc_eff = 9'd1;
    end else if (frame_cols_r > 9'(wcb_pkg::MAX_COLS)) begin
      nc_eff = 9'(wcb_pkg::MAX_COLS);
    end else begin
      nc_eff = frame_cols_r;
    end
    reflect = (border_mode_r == wcb_pkg::BM_REFLECT);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r   <= 3'd1;
      half_height_r  <= 3'd1;
      frame_rows_r   <= 9'd256;
      frame_cols_r   <= 9'd256;
      border_mode_r  <= wcb_pkg::BM_REFLECT;
      output_scale_r <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        wcb_pkg::CFG_HALF_WIDTH:   half_width_r   <= cfg_data[2:0];
        wcb_pkg::CFG_HALF_HEIGHT:  half_height_r  <= cfg_data[2:0];
        wcb_pkg::CFG_FRAME_ROWS:   frame_rows_r   <= cfg_data[8:0];
        wcb_pkg::CFG_FRAME_COLS:   frame_cols_r   <= cfg_data[8:0];
        wcb_pkg::CFG_BORDER_MODE:  border_mode_r  <= cfg_data[1:0];
        wcb_pkg::CFG_OUTPUT_SCALE: output_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input acceptance and position checks of a compute beat.
  assign in_stall = (state_r != wcb_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign outside_frame = ({1'b0, in_row} >= nr_eff) || ({1'b0, in_col} >= nc_eff);
  assign outside_valid = (border_mode_r == wcb_pkg::BM_VALID) &&
                         ((in_row < {5'b0, hh_eff}) ||
                          ($signed({3'b000, in_row}) >=
                           $signed({2'b00, nr_eff}) - $signed({8'b0, hh_eff})) ||
                          (in_col < {5'b0, hw_eff}) ||
                          ($signed({3'b000, in_col}) >=
                           $signed({2'b00, nc_eff}) - $signed({8'b0, hw_eff})));

  // Store writes.
  assign pix_we = in_acc && (in_operation == wcb_pkg::OP_PIXEL) &&
                  ({1'b0, in_row} < 9'(wcb_pkg::MAX_ROWS)) &&
                  ({1'b0, in_col} < 9'(wcb_pkg::MAX_COLS));
  assign tap_we = in_acc && (in_operation == wcb_pkg::OP_WEIGHT) &&
                  ({1'b0, in_tap_index} < 9'(wcb_pkg::TAP_DEPTH));
  assign pix_wr_addr = wcb_pkg::PIX_AW'(in_row) * wcb_pkg::PIX_AW'(wcb_pkg::MAX_COLS) +
                       wcb_pkg::PIX_AW'(in_col);

  // Window walk: source coordinates of the current tap.
  assign tx_last = (tx_r == {hw_eff, 1'b0});
  assign ty_last = (ty_r == {hh_eff, 1'b0});
  assign iy_raw  = $signed({3'b000, row_r}) + $signed({7'b0, ty_r}) -
                   $signed({8'b0, hh_eff});
  assign ix_raw  = $signed({3'b000, col_r}) + $signed({7'b0, tx_r}) -
                   $signed({8'b0, hw_eff});
  assign iy = edge_idx(iy_raw, nr_eff, reflect);
  assign ix = edge_idx(ix_raw, nc_eff, reflect);
  assign pix_rd_addr = wcb_pkg::PIX_AW'(iy) * wcb_pkg::PIX_AW'(wcb_pkg::MAX_COLS) +
                       wcb_pkg::PIX_AW'(ix);

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (pix_we) begin
      frame_mem[pix_wr_addr] <= in_pixel_value;
    end
    rd_p_r <= frame_mem[pix_rd_addr];
  end

  // Weight store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (tap_we) begin
      weight_mem[in_tap_index[wcb_pkg::TAP_AW-1:0]] <= in_tap_weight;
    end
    rd_w_r <= weight_mem[tap_r];
  end

  // Rounding of the scaled magnitude and saturation to 48 bits.
  assign round_sum = {22'b0, p0_r} + {p1_r, 22'b0} + 68'h8000;
  always_comb begin
    if (neg_r) begin
      sat_value = (res_r > 52'h8000_0000_0000) ? 48'sh8000_0000_0000
                                               : -$signed(res_r[47:0]);
    end else begin
      sat_value = (res_r > 52'h7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF
                                               : $signed(res_r[47:0]);
    end
  end

  // Sequencer next state and output register control.
  assign emit_go = !out_valid_r || !out_stall;
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      wcb_pkg::S_IDLE: begin
        if (in_acc && (in_operation == wcb_pkg::OP_COMPUTE)) begin
          state_nxt = (outside_frame || outside_valid) ? wcb_pkg::S_EMIT
                                                       : wcb_pkg::S_RUN;
        end
      end
      wcb_pkg::S_RUN: begin
        if (tx_last && ty_last) begin
          state_nxt = wcb_pkg::S_DRAIN;
        end
      end
      wcb_pkg::S_DRAIN: begin
        if (!rd_vld_r && !prod_vld_r) begin
          state_nxt = wcb_pkg::S_MUL_LO;
        end
      end
      wcb_pkg::S_MUL_LO: state_nxt = wcb_pkg::S_MUL_HI;
      wcb_pkg::S_MUL_HI: state_nxt = wcb_pkg::S_ROUND;
      wcb_pkg::S_ROUND:  state_nxt = wcb_pkg::S_EMIT;
      wcb_pkg::S_EMIT: begin
        if (emit_go) begin
          state_nxt     = wcb_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = wcb_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wcb_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= (state_r == wcb_pkg::S_RUN);
      prod_vld_r  <= rd_vld_r;
    end
  end

  // Window counters and the captured request.
  always_ff @(posedge clk) begin
    if (state_r == wcb_pkg::S_IDLE) begin
      row_r <= in_row;
      col_r <= in_col;
      tx_r  <= 4'd0;
      ty_r  <= 4'd0;
      tap_r <= '0;
      if (outside_frame) begin
        status_r <= wcb_pkg::ST_FRAME;
      end else if (outside_valid) begin
        status_r <= wcb_pkg::ST_BORDER;
      end else begin
        status_r <= wcb_pkg::ST_OK;
      end
    end else if (state_r == wcb_pkg::S_RUN) begin
      tap_r <= tap_r + 1'b1;
      if (tx_last) begin
        tx_r <= 4'd0;
        ty_r <= ty_r + 4'd1;
      end else begin
        tx_r <= tx_r + 4'd1;
      end
    end
  end

  // Multiply-accumulate pipeline, then the two-part scale multiply.
  always_ff @(posedge clk) begin
    prod_r <= rd_w_r * rd_p_r;
    if (state_r == wcb_pkg::S_IDLE) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + {{8{prod_r[35]}}, prod_r};
    end
    if (state_r == wcb_pkg::S_DRAIN) begin
      neg_r <= acc_r[43];
      mag_r <= acc_r[43] ? 44'(-acc_r) : 44'(acc_r);
    end
    if (state_r == wcb_pkg::S_MUL_LO) begin
      p0_r <= mag_r[21:0] * output_scale_r;
    end
    if (state_r == wcb_pkg::S_MUL_HI) begin
      p1_r <= mag_r[43:22] * output_scale_r;
    end
    if (state_r == wcb_pkg::S_ROUND) begin
      res_r <= round_sum[67:16];
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if ((state_r == wcb_pkg::S_EMIT) && emit_go) begin
      out_status_r <= status_r;
      out_value_r  <= (status_r == wcb_pkg::ST_OK) ? sat_value : 48'sd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_value_r;
  assign out_status         = out_status_r;

endmodule

[rtl/wcb_checker.sv]
// ----------------------------------------------------------------------------
// wcb_checker: port-level assertions for the windowed convolution engine
// Watches the input, result and handshake ports over time; bound to the
// top level below.
// ----------------------------------------------------------------------------
module wcb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_operation,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [47:0] out_filtered_value,
  input logic [1:0]         out_status
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_filtered_value) && $stable(out_status))
    else $error("result payload changed while stalled");

  // A rejected position reports a zero value.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != wcb_pkg::ST_OK) |-> (out_filtered_value == 48'sd0))
    else $error("nonzero value with error status");

  // A compute beat occupies the engine for at least the next cycle.
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == wcb_pkg::OP_COMPUTE) |=> in_stall)
    else $error("input taken right after a compute beat");

  // Store writes never block the input.
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation != wcb_pkg::OP_COMPUTE) |=> !in_stall)
    else $error("input stalled after a store write");

endmodule

bind window_convolve_with_borders wcb_checker u_wcb_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_operation       (in_operation),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_filtered_value (out_filtered_value),
  .out_status         (out_status)
);
